FILE: src/pvlg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvlg_pkg
// Shared types and constants for the pump and valve leak guard.
// ----------------------------------------------------------------------------
package pvlg_pkg;

    localparam int LEVEL_W = 10;
    localparam int TIME_W  = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    localparam logic [LEVEL_W-1:0] RST_LEAK_THRESHOLD = 10'd500;
    localparam logic [TIME_W-1:0]  RST_VALVE_TRAVEL   = 16'd5000;
    localparam logic [TIME_W-1:0]  RST_NORMAL_CHECK   = 16'd1000;
    localparam logic [TIME_W-1:0]  RST_ALARM_CHECK    = 16'd500;
    localparam logic [TIME_W-1:0]  RST_BEEP_PERIOD    = 16'd1000;

    typedef enum logic [IDX_W-1:0] {
        REG_LEAK_THRESHOLD = 3'd0,
        REG_VALVE_TRAVEL   = 3'd1,
        REG_NORMAL_CHECK   = 3'd2,
        REG_ALARM_CHECK    = 3'd3,
        REG_BEEP_PERIOD    = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_RUN    = 2'd1,
        MODE_MOVING = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        VALVE_OPENING = 2'd0,
        VALVE_OPENED  = 2'd1,
        VALVE_CLOSING = 2'd2,
        VALVE_CLOSED  = 2'd3
    } valve_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] leak_threshold;
        logic [TIME_W-1:0]  valve_travel_ms;
        logic [TIME_W-1:0]  normal_check_ms;
        logic [TIME_W-1:0]  alarm_check_ms;
        logic [TIME_W-1:0]  beep_period_ms;
    } cfg_t;

    typedef struct packed {
        logic       pump_run;
        logic       open_drive;
        logic       close_drive;
        logic       beep_start;
        logic       beep_stop;
        logic       leak_flag;
        logic       supply_flag;
        logic [1:0] valve_position;
        logic [1:0] manager_mode;
    } result_t;

endpackage

FILE: src/pump_valve_leak_guard_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_valve_leak_guard_top
// Leak and supply guard for a pump and a motorized valve, one tick per
// transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick carrying the analog leak
// reading, the leak contact and the supply-ok level. Each tick produces one
// output transaction with the pump and coil drives, beeper pulses, alarm
// flags, valve position and mode after that tick's update.
// Both channels use valid and stall; a transaction moves on an edge where
// valid is high and stall is low. The tick lands in an input register and
// the state update runs combinationally from there into the output register,
// which drives out_valid, and one tick is accepted every cycle while the
// receiver does not stall. When the receiver stalls, the output register holds
// its transaction, the input register fills and then in_stall rises.
// Reset clears both stages, sets the configuration registers to their
// defaults and puts the guard in start mode with the valve taken as open.
// Configuration writes through cfg_we take effect on the next edge and
// should only be made while no tick is in flight.
// ----------------------------------------------------------------------------
module pump_valve_leak_guard_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pvlg_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pvlg_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pvlg_pkg::LEVEL_W-1:0]  leak_level,
    input  logic                          leak_contact,
    input  logic                          supply_ok,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pump_run,
    output logic                          open_drive,
    output logic                          close_drive,
    output logic                          beep_start,
    output logic                          beep_stop,
    output logic                          leak_flag,
    output logic                          supply_flag,
    output logic [1:0]                    valve_position,
    output logic [1:0]                    manager_mode
);

    pvlg_pkg::cfg_t                 cfg;
    pvlg_pkg::result_t              result;
    pvlg_pkg::result_t              res_reg;
    logic                           in_vld_reg;
    logic [pvlg_pkg::LEVEL_W-1:0]   level_reg;
    logic                           contact_reg;
    logic                           supply_reg;
    logic                           out_vld_reg;
    logic                           advance;
    logic                           step;
    logic                           in_take;

    assign advance  = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    pvlg_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pvlg_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .leak_level   (level_reg),
        .leak_contact (contact_reg),
        .supply_ok    (supply_reg),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            level_reg   <= leak_level;
            contact_reg <= leak_contact;
            supply_reg  <= supply_ok;
        end
        if (step)
            res_reg <= result;
    end

    assign out_valid      = out_vld_reg;
    assign pump_run       = res_reg.pump_run;
    assign open_drive     = res_reg.open_drive;
    assign close_drive    = res_reg.close_drive;
    assign beep_start     = res_reg.beep_start;
    assign beep_stop      = res_reg.beep_stop;
    assign leak_flag      = res_reg.leak_flag;
    assign supply_flag    = res_reg.supply_flag;
    assign valve_position = res_reg.valve_position;
    assign manager_mode   = res_reg.manager_mode;

endmodule

FILE: src/pvlg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvlg_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pvlg_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pvlg_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pvlg_pkg::CFG_W-1:0]    cfg_data,
    output pvlg_pkg::cfg_t                cfg
);

    pvlg_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leak_threshold  <= pvlg_pkg::RST_LEAK_THRESHOLD;
            cfg_reg.valve_travel_ms <= pvlg_pkg::RST_VALVE_TRAVEL;
            cfg_reg.normal_check_ms <= pvlg_pkg::RST_NORMAL_CHECK;
            cfg_reg.alarm_check_ms  <= pvlg_pkg::RST_ALARM_CHECK;
            cfg_reg.beep_period_ms  <= pvlg_pkg::RST_BEEP_PERIOD;
        end
        else if (cfg_we)
        begin
            // Writes to an index past the last register are dropped.
            unique case (pvlg_pkg::cfg_idx_t'(cfg_index))
                pvlg_pkg::REG_LEAK_THRESHOLD:
                    cfg_reg.leak_threshold <= cfg_data[pvlg_pkg::LEVEL_W-1:0];
                pvlg_pkg::REG_VALVE_TRAVEL: cfg_reg.valve_travel_ms <= cfg_data;
                pvlg_pkg::REG_NORMAL_CHECK: cfg_reg.normal_check_ms <= cfg_data;
                pvlg_pkg::REG_ALARM_CHECK:  cfg_reg.alarm_check_ms  <= cfg_data;
                pvlg_pkg::REG_BEEP_PERIOD:  cfg_reg.beep_period_ms  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/pvlg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvlg_core
// Guard state and its one-tick update: countdowns, beeper and valve control.
// ----------------------------------------------------------------------------
module pvlg_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [pvlg_pkg::LEVEL_W-1:0]   leak_level,
    input  logic                           leak_contact,
    input  logic                           supply_ok,
    input  pvlg_pkg::cfg_t                 cfg,
    output pvlg_pkg::result_t              result
);

    pvlg_pkg::mode_t                mode_reg, mode_next;
    pvlg_pkg::valve_t               valve_reg, valve_next;
    logic                           pump_reg, pump_next;
    logic                           open_reg, open_next;
    logic                           close_reg, close_next;
    logic [pvlg_pkg::TIME_W-1:0]    check_reg, check_next;
    logic [pvlg_pkg::TIME_W-1:0]    beep_reg, beep_next;
    logic                           tone_reg, tone_next;
    logic                           leak_reg, leak_next;
    logic                           supply_reg, supply_next;

    logic [pvlg_pkg::TIME_W-1:0]    check_dec;
    logic [pvlg_pkg::TIME_W-1:0]    beep_dec;
    logic                           start_pulse;
    logic                           stop_pulse;
    logic                           alarm_any;

    always_comb
    begin
        check_dec = (check_reg == '0) ? '0 : check_reg - 1'b1;
        beep_dec  = (beep_reg == '0) ? '0 : beep_reg - 1'b1;

        // The beeper looks at the alarms latched before this tick.
        beep_next   = beep_dec;
        tone_next   = tone_reg;
        start_pulse = 1'b0;
        stop_pulse  = 1'b0;
        if (beep_dec == '0)
        begin
            beep_next = cfg.beep_period_ms;
            if (leak_reg || supply_reg)
            begin
                start_pulse = 1'b1;
                tone_next   = 1'b1;
            end
            else if (tone_reg)
            begin
                stop_pulse = 1'b1;
                tone_next  = 1'b0;
            end
        end

        mode_next   = mode_reg;
        valve_next  = valve_reg;
        pump_next   = pump_reg;
        open_next   = open_reg;
        close_next  = close_reg;
        check_next  = check_dec;
        leak_next   = leak_reg;
        supply_next = supply_reg;
        alarm_any   = 1'b0;

        unique case (mode_reg)
            pvlg_pkg::MODE_RUN:
            begin
                if (check_dec == '0)
                begin
                    supply_next = ~supply_ok;
                    leak_next   = (leak_level > cfg.leak_threshold) || leak_contact;
                    alarm_any   = leak_next || supply_next;
                    if (alarm_any)
                    begin
                        check_next = cfg.alarm_check_ms;
                        if (valve_reg == pvlg_pkg::VALVE_OPENED)
                        begin
                            pump_next  = 1'b0;
                            open_next  = 1'b0;
                            close_next = 1'b1;
                            valve_next = pvlg_pkg::VALVE_CLOSING;
                            check_next = cfg.valve_travel_ms;
                            mode_next  = pvlg_pkg::MODE_MOVING;
                        end
                    end
                    else
                    begin
                        check_next = cfg.normal_check_ms;
                        if (valve_reg == pvlg_pkg::VALVE_CLOSED)
                        begin
                            pump_next  = 1'b1;
                            close_next = 1'b0;
                            open_next  = 1'b1;
                            valve_next = pvlg_pkg::VALVE_OPENING;
                            check_next = cfg.valve_travel_ms;
                            mode_next  = pvlg_pkg::MODE_MOVING;
                        end
                    end
                end
            end
            pvlg_pkg::MODE_MOVING:
            begin
                if (check_dec == '0)
                begin
                    open_next  = 1'b0;
                    close_next = 1'b0;
                    if (valve_reg == pvlg_pkg::VALVE_CLOSING)
                        valve_next = pvlg_pkg::VALVE_CLOSED;
                    else if (valve_reg == pvlg_pkg::VALVE_OPENING)
                        valve_next = pvlg_pkg::VALVE_OPENED;
                    mode_next = pvlg_pkg::MODE_RUN;
                end
            end
            default:
            begin
                // Start: the valve is taken as open and is driven closed.
                pump_next  = 1'b0;
                open_next  = 1'b0;
                close_next = 1'b1;
                valve_next = pvlg_pkg::VALVE_CLOSING;
                check_next = cfg.valve_travel_ms;
                mode_next  = pvlg_pkg::MODE_MOVING;
            end
        endcase

        result.pump_run       = pump_next;
        result.open_drive     = open_next;
        result.close_drive    = close_next;
        result.beep_start     = start_pulse;
        result.beep_stop      = stop_pulse;
        result.leak_flag      = leak_next;
        result.supply_flag    = supply_next;
        result.valve_position = valve_next;
        result.manager_mode   = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pvlg_pkg::MODE_START;
            valve_reg  <= pvlg_pkg::VALVE_OPENED;
            pump_reg   <= 1'b0;
            open_reg   <= 1'b0;
            close_reg  <= 1'b0;
            check_reg  <= '0;
            beep_reg   <= '0;
            tone_reg   <= 1'b0;
            leak_reg   <= 1'b0;
            supply_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            valve_reg  <= valve_next;
            pump_reg   <= pump_next;
            open_reg   <= open_next;
            close_reg  <= close_next;
            check_reg  <= check_next;
            beep_reg   <= beep_next;
            tone_reg   <= tone_next;
            leak_reg   <= leak_next;
            supply_reg <= supply_next;
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pump and valve leak guard.
// ----------------------------------------------------------------------------
// Ticks are queued by a stimulus process and offered by a clocked driver. The
// driver runs a tick-level prediction of the guard on every accepted
// transaction. A clocked monitor compares every output transaction field by
// field with the oldest prediction. The run starts with a short directed
// sequence. Several phases follow, each with its own register settings and a
// chosen amount of idling on both channels. The episodes of dry, leaking and
// supply-fault ticks each hold their condition over a random span.
// ----------------------------------------------------------------------------
module testbench;
    import pvlg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_LEVEL   = (1 << LEVEL_W) - 1;
    localparam logic [IDX_W-1:0] FIRST_UNUSED_REG = 3'd5;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               contact;
        logic               supply;
    } tick_t;

    typedef enum {EP_DRY, EP_LEAK_LEVEL, EP_LEAK_CONTACT, EP_SUPPLY_FAULT, EP_NOISE} episode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [LEVEL_W-1:0]  leak_level = '0;
    logic                leak_contact = 1'b0;
    logic                supply_ok = 1'b1;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                pump_run;
    logic                open_drive;
    logic                close_drive;
    logic                beep_start;
    logic                beep_stop;
    logic                leak_flag;
    logic                supply_flag;
    logic [1:0]          valve_position;
    logic [1:0]          manager_mode;

    pump_valve_leak_guard_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .leak_level     (leak_level),
        .leak_contact   (leak_contact),
        .supply_ok      (supply_ok),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pump_run       (pump_run),
        .open_drive     (open_drive),
        .close_drive    (close_drive),
        .beep_start     (beep_start),
        .beep_stop      (beep_stop),
        .leak_flag      (leak_flag),
        .supply_flag    (supply_flag),
        .valve_position (valve_position),
        .manager_mode   (manager_mode)
    );

    // Guard state as the predictor sees it, starting from the reset values.
    cfg_t              guard_cfg;
    mode_t             pred_mode = MODE_START;
    valve_t            pred_valve = VALVE_OPENED;
    logic              pred_pump = 1'b0;
    logic              pred_open_coil = 1'b0;
    logic              pred_close_coil = 1'b0;
    logic              pred_tone = 1'b0;
    logic              pred_leak = 1'b0;
    logic              pred_supply = 1'b0;
    logic [TIME_W-1:0] pred_check_left = '0;
    logic [TIME_W-1:0] pred_beep_left = '0;

    tick_t   ticks_to_send[$];
    result_t predicted_outputs[$];
    tick_t   offered;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int ticks_checked = 0;
    int valve_trips = 0;
    int start_pulses = 0;
    int stop_pulses = 0;
    int leak_ticks = 0;
    int supply_ticks = 0;
    logic [1:0] last_mode = 2'd0;
    result_t seen;
    result_t wanted;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit try_close();
        if (pred_valve != VALVE_OPENED)
            return 1'b0;
        pred_pump = 1'b0;
        pred_open_coil = 1'b0;
        pred_close_coil = 1'b1;
        pred_valve = VALVE_CLOSING;
        pred_check_left = guard_cfg.valve_travel_ms;
        return 1'b1;
    endfunction

    function automatic bit try_open();
        if (pred_valve != VALVE_CLOSED)
            return 1'b0;
        pred_pump = 1'b1;
        pred_close_coil = 1'b0;
        pred_open_coil = 1'b1;
        pred_valve = VALVE_OPENING;
        pred_check_left = guard_cfg.valve_travel_ms;
        return 1'b1;
    endfunction

    function automatic logic [CFG_W-1:0] rand_cfg(input int lo, input int hi);
        return CFG_W'($urandom_range(hi, lo));
    endfunction

    // One millisecond tick: countdowns, then the beeper, then the mode step.
    function automatic result_t guard_tick(input tick_t t);
        result_t r;
        r = '0;
        if (pred_check_left != 0)
            pred_check_left = pred_check_left - 1'b1;
        if (pred_beep_left != 0)
            pred_beep_left = pred_beep_left - 1'b1;

        if (pred_beep_left == 0)
        begin
            pred_beep_left = guard_cfg.beep_period_ms;
            if (pred_leak || pred_supply)
            begin
                r.beep_start = 1'b1;
                pred_tone = 1'b1;
            end
            else if (pred_tone)
            begin
                r.beep_stop = 1'b1;
                pred_tone = 1'b0;
            end
        end

        case (pred_mode)
            MODE_RUN:
            begin
                if (pred_check_left == 0)
                begin
                    pred_supply = !t.supply;
                    pred_leak = (t.level > guard_cfg.leak_threshold) || t.contact;
                    if (pred_leak || pred_supply)
                    begin
                        pred_check_left = guard_cfg.alarm_check_ms;
                        if (try_close())
                            pred_mode = MODE_MOVING;
                    end
                    else
                    begin
                        pred_check_left = guard_cfg.normal_check_ms;
                        if (try_open())
                            pred_mode = MODE_MOVING;
                    end
                end
            end
            MODE_MOVING:
            begin
                if (pred_check_left == 0)
                begin
                    pred_open_coil = 1'b0;
                    pred_close_coil = 1'b0;
                    if (pred_valve == VALVE_CLOSING)
                        pred_valve = VALVE_CLOSED;
                    else if (pred_valve == VALVE_OPENING)
                        pred_valve = VALVE_OPENED;
                    pred_mode = MODE_RUN;
                end
            end
            default:
            begin
                // Start mode takes the valve as open, so closing always begins.
                pred_valve = VALVE_OPENED;
                if (try_close())
                    pred_mode = MODE_MOVING;
            end
        endcase

        r.pump_run = pred_pump;
        r.open_drive = pred_open_coil;
        r.close_drive = pred_close_coil;
        r.leak_flag = pred_leak;
        r.supply_flag = pred_supply;
        r.valve_position = pred_valve;
        r.manager_mode = pred_mode;
        return r;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_LEAK_THRESHOLD: guard_cfg.leak_threshold = data[LEVEL_W-1:0];
            REG_VALVE_TRAVEL:   guard_cfg.valve_travel_ms = data;
            REG_NORMAL_CHECK:   guard_cfg.normal_check_ms = data;
            REG_ALARM_CHECK:    guard_cfg.alarm_check_ms = data;
            REG_BEEP_PERIOD:    guard_cfg.beep_period_ms = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Writes every register, plus one index past the end that must be ignored.
    task automatic configure(input logic [CFG_W-1:0] threshold, input logic [CFG_W-1:0] travel,
                             input logic [CFG_W-1:0] normal, input logic [CFG_W-1:0] alarm,
                             input logic [CFG_W-1:0] beep);
        write_reg(REG_LEAK_THRESHOLD, threshold);
        write_reg(REG_VALVE_TRAVEL, travel);
        write_reg(REG_NORMAL_CHECK, normal);
        write_reg(REG_ALARM_CHECK, alarm);
        write_reg(REG_BEEP_PERIOD, beep);
        write_reg(IDX_W'($urandom_range((1 << IDX_W) - 1, FIRST_UNUSED_REG)),
                  rand_cfg(0, 65535));
    endtask

    task automatic push_tick(input int level, input logic contact, input logic supply);
        tick_t t;
        t.level = LEVEL_W'(level);
        t.contact = contact;
        t.supply = supply;
        ticks_to_send.push_back(t);
    endtask

    // Episodes of a steady condition let the check countdowns expire under it,
    // so the valve really travels; the noise episodes break the pattern.
    task automatic queue_episodes(input int count);
        episode_t kind;
        int span;
        int w;
        int thr;
        tick_t t;
        while (count > 0)
        begin
            w = $urandom_range(0, 99);
            kind = (w < 35) ? EP_DRY : (w < 50) ? EP_LEAK_LEVEL : (w < 65) ? EP_LEAK_CONTACT :
                   (w < 80) ? EP_SUPPLY_FAULT : EP_NOISE;
            span = $urandom_range(1, 25);
            thr = int'(guard_cfg.leak_threshold);
            while (span > 0 && count > 0)
            begin
                t.level = LEVEL_W'($urandom_range(thr, 0));
                t.contact = 1'b0;
                t.supply = 1'b1;
                case (kind)
                    EP_LEAK_LEVEL:
                    begin
                        if (thr < MAX_LEVEL)
                            t.level = LEVEL_W'($urandom_range(MAX_LEVEL, thr + 1));
                        else
                            t.contact = 1'b1;
                    end
                    EP_LEAK_CONTACT:
                    begin
                        t.contact = 1'b1;
                        t.supply = ($urandom_range(0, 3) != 0);
                    end
                    EP_SUPPLY_FAULT: t.supply = 1'b0;
                    EP_NOISE:
                    begin
                        t.level = LEVEL_W'($urandom_range(MAX_LEVEL, 0));
                        t.contact = 1'($urandom_range(0, 1));
                        t.supply = 1'($urandom_range(0, 1));
                    end
                    default: ;
                endcase
                ticks_to_send.push_back(t);
                span--;
                count--;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (ticks_to_send.size() != 0 || in_valid || predicted_outputs.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [1:0] want, input logic [1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Driver: a held transaction keeps its payload until it is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predicted_outputs.push_back(guard_tick(offered));
            if (!in_valid || !in_stall)
            begin
                if (ticks_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered = ticks_to_send.pop_front();
                    in_valid <= 1'b1;
                    leak_level <= offered.level;
                    leak_contact <= offered.contact;
                    supply_ok <= offered.supply;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold, counted here and applied by the monitor.
    always @(posedge clk)
    begin
        if (holds_served < hold_requests)
        begin
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: checks output transactions and decides the output stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = {pump_run, open_drive, close_drive, beep_start, beep_stop,
                        leak_flag, supply_flag, valve_position, manager_mode};
                if (predicted_outputs.size() == 0)
                begin
                    $error("output transaction with no prediction waiting");
                    mismatch_count++;
                end
                else
                begin
                    wanted = predicted_outputs.pop_front();
                    check_field("pump_run", 2'(wanted.pump_run), 2'(seen.pump_run));
                    check_field("open_drive", 2'(wanted.open_drive), 2'(seen.open_drive));
                    check_field("close_drive", 2'(wanted.close_drive), 2'(seen.close_drive));
                    check_field("beep_start", 2'(wanted.beep_start), 2'(seen.beep_start));
                    check_field("beep_stop", 2'(wanted.beep_stop), 2'(seen.beep_stop));
                    check_field("leak_flag", 2'(wanted.leak_flag), 2'(seen.leak_flag));
                    check_field("supply_flag", 2'(wanted.supply_flag), 2'(seen.supply_flag));
                    check_field("valve_position", wanted.valve_position, seen.valve_position);
                    check_field("manager_mode", wanted.manager_mode, seen.manager_mode);
                end
                ticks_checked++;
                if (seen.manager_mode == MODE_MOVING && last_mode != MODE_MOVING)
                    valve_trips++;
                last_mode = seen.manager_mode;
                start_pulses += seen.beep_start;
                stop_pulses += seen.beep_stop;
                leak_ticks += seen.leak_flag;
                supply_ticks += seen.supply_flag;
            end

            if (hold_left > 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        guard_cfg.leak_threshold = RST_LEAK_THRESHOLD;
        guard_cfg.valve_travel_ms = RST_VALVE_TRAVEL;
        guard_cfg.normal_check_ms = RST_NORMAL_CHECK;
        guard_cfg.alarm_check_ms = RST_ALARM_CHECK;
        guard_cfg.beep_period_ms = RST_BEEP_PERIOD;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: short periods so the valve closes, opens and
        // closes again within a couple of dozen ticks.
        configure(16'd512, 16'd2, 16'd2, 16'd1, 16'd1);
        push_tick(0, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b1);
        push_tick(512, 1'b0, 1'b1);
        push_tick(512, 1'b0, 1'b1);
        push_tick(512, 1'b0, 1'b1);
        push_tick(513, 1'b0, 1'b1);
        push_tick(MAX_LEVEL, 1'b0, 1'b1);
        push_tick(MAX_LEVEL, 1'b0, 1'b1);
        push_tick(MAX_LEVEL, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b0);
        push_tick(0, 1'b0, 1'b0);
        push_tick(0, 1'b0, 1'b0);
        push_tick(0, 1'b1, 1'b1);
        push_tick(0, 1'b1, 1'b1);
        push_tick(MAX_LEVEL, 1'b1, 1'b0);
        push_tick(MAX_LEVEL, 1'b1, 1'b0);
        push_tick(0, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b1);
        push_tick(0, 1'b0, 1'b1);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(rand_cfg(0, 65535), rand_cfg(1, 12), rand_cfg(1, 10),
                  rand_cfg(1, 6), rand_cfg(1, 8));
        queue_episodes(95);
        wait_drained();

        send_idle_pct = 52;
        recv_stall_pct = 0;
        configure(rand_cfg(0, 65535), rand_cfg(1, 12), rand_cfg(1, 10),
                  rand_cfg(1, 6), rand_cfg(1, 8));
        queue_episodes(95);
        wait_drained();

        // A long output hold while the sender keeps offering fills the pipe.
        send_idle_pct = 0;
        recv_stall_pct = 52;
        configure(rand_cfg(0, 65535), rand_cfg(1, 12), rand_cfg(1, 10),
                  rand_cfg(1, 6), rand_cfg(1, 8));
        hold_requests++;
        queue_episodes(95);
        wait_drained();

        // The sender stops halfway until every prediction has been matched.
        send_idle_pct = 30;
        recv_stall_pct = 30;
        configure(rand_cfg(0, 65535), rand_cfg(1, 12), rand_cfg(1, 10),
                  rand_cfg(1, 6), rand_cfg(1, 8));
        queue_episodes(48);
        wait_drained();
        queue_episodes(47);
        wait_drained();

        // Zero periods expire on the very next tick.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_episodes(60);
        wait_drained();

        // Upper extremes; the threshold write carries bits above its width.
        send_idle_pct = 30;
        recv_stall_pct = 30;
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_episodes(40);
        wait_drained();
        repeat (10) @(posedge clk);

        if (predicted_outputs.size() != 0)
        begin
            $error("%0d predicted transactions never arrived", predicted_outputs.size());
            mismatch_count++;
        end
        $display("Checked %0d ticks over a directed start and six phases: %0d valve trips,",
                 ticks_checked, valve_trips);
        $display("%0d beep starts, %0d beep stops, leak flag on %0d ticks, supply flag on %0d ticks.",
                 start_pulses, stop_pulses, leak_ticks, supply_ticks);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: pump_valve_leak_guard_top.f
src/pvlg_pkg.sv
src/pvlg_cfg.sv
src/pvlg_core.sv
src/pump_valve_leak_guard_top.sv
tb/testbench.sv
